FILE: hw/rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg: shared definitions for the heap sort core
// Sizes, transaction payload types, sequencer states and the compare unit's
// request and response structures.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

	// Store depth and element width.
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;

	// Fixed field widths of the transactions.
	localparam int VALUE_W = 32;
	localparam int CMP_W   = 12;

	// Derived widths: store address, element count, child index.
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = CNT_W + 1;

	typedef logic [DATA_WIDTH-1:0] elem_t;
	typedef logic [AW-1:0]         addr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CMP_W-1:0]      cmp_cnt_t;
	typedef logic [VALUE_W-1:0]    value_t;

	// Saturation limit of the comparison counter.
	localparam cmp_cnt_t CMP_MAX = '1;

	// Input transaction.
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} in_item_t;

	// Result transaction.
	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      final_item;
		logic [CMP_W-1:0]          compare_count;
		logic                      overflow;
	} out_item_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_CHILD_RD,
		ST_CHILD_CMP,
		ST_NEXT,
		ST_OUT_RD,
		ST_OUT_CAP,
		ST_OUT_WAIT
	} state_t;

	// Sort phase: heap build, then root extraction.
	typedef enum logic {
		PH_BUILD,
		PH_EXTRACT
	} phase_t;

	// Request to the compare unit: the value being sifted and both children.
	typedef struct packed {
		elem_t held;
		elem_t left;
		elem_t right;
		logic  left_ok;
		logic  right_ok;
	} cmp_req_t;

	// Response of the compare unit.
	typedef struct packed {
		logic  swap;
		logic  pick_right;
		elem_t big_val;
	} cmp_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hsc_ram.sv
// ----------------------------------------------------------------------------
// hsc_ram: generic memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read ports.
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/hsc_cmp.sv
// ----------------------------------------------------------------------------
// hsc_cmp: shared sift compare unit
// Picks the largest of the sifted value and its valid children, signed order.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_cmp (
	input  wire hsc_pkg::cmp_req_t req,
	output hsc_pkg::cmp_res_t      res
);

	always_comb begin
		hsc_pkg::elem_t big;
		logic           swap;
		logic           right;
		big   = req.held;
		swap  = 1'b0;
		right = 1'b0;
		// Left child wins only when strictly larger; equal values stay put.
		if (req.left_ok && ($signed(req.left) > $signed(big))) begin
			big  = req.left;
			swap = 1'b1;
		end
		if (req.right_ok && ($signed(req.right) > $signed(big))) begin
			big   = req.right;
			swap  = 1'b1;
			right = 1'b1;
		end
		res.swap       = swap;
		res.pick_right = right;
		res.big_val    = big;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/hsc_ctrl.sv
// ----------------------------------------------------------------------------
// hsc_ctrl: heap sort sequencer
// Loads elements, runs heap build and extraction through the shared compare
// unit, counts comparisons and streams the sorted set out.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hsc_pkg::in_item_t  item,
	input  wire logic               item_valid,
	output logic                    item_stall,
	output hsc_pkg::out_item_t      result,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic                    mem_we,
	output hsc_pkg::addr_t          mem_waddr,
	output hsc_pkg::elem_t          mem_wdata,
	output hsc_pkg::addr_t          mem_raddr_a,
	output hsc_pkg::addr_t          mem_raddr_b,
	input  wire hsc_pkg::elem_t     mem_rdata_a,
	input  wire hsc_pkg::elem_t     mem_rdata_b,
	output hsc_pkg::cmp_req_t       cmp_req,
	input  wire hsc_pkg::cmp_res_t  cmp_res
);

	hsc_pkg::state_t    state_q, state_d;
	hsc_pkg::phase_t    phase_q;
	hsc_pkg::cnt_t      count_q;
	hsc_pkg::cnt_t      k_q;
	hsc_pkg::cnt_t      len_q;
	hsc_pkg::cnt_t      out_idx_q;
	hsc_pkg::addr_t     node_q;
	hsc_pkg::cmp_cnt_t  total_q;
	logic               dropped_q;
	logic               result_valid_q;
	hsc_pkg::elem_t     held_q;
	hsc_pkg::out_item_t result_q;

	logic           accept_in;
	logic           room;
	hsc_pkg::idx_t  lc_idx;
	hsc_pkg::idx_t  rc_idx;
	hsc_pkg::addr_t k_addr;

	assign accept_in = item_valid && !item_stall;
	assign room      = count_q < hsc_pkg::cnt_t'(hsc_pkg::DEPTH);
	assign k_addr    = hsc_pkg::addr_t'(k_q - hsc_pkg::cnt_t'(1));

	// Child positions of the current node in the heap.
	assign lc_idx = hsc_pkg::idx_t'({node_q, 1'b0}) + hsc_pkg::idx_t'(1);
	assign rc_idx = lc_idx + hsc_pkg::idx_t'(1);

	// Compare request: held value against the children read last cycle.
	assign cmp_req.held     = held_q;
	assign cmp_req.left     = mem_rdata_a;
	assign cmp_req.right    = mem_rdata_b;
	assign cmp_req.left_ok  = lc_idx < hsc_pkg::idx_t'(len_q);
	assign cmp_req.right_ok = rc_idx < hsc_pkg::idx_t'(len_q);

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// Next state and memory port control.
	always_comb begin
		state_d     = state_q;
		item_stall  = (state_q != hsc_pkg::ST_IDLE);
		mem_we      = 1'b0;
		mem_waddr   = hsc_pkg::addr_t'(count_q);
		mem_wdata   = hsc_pkg::elem_t'($unsigned(item.value));
		mem_raddr_a = '0;
		mem_raddr_b = '0;
		case (state_q)
			hsc_pkg::ST_IDLE: begin
				if (accept_in) begin
					mem_we = room;
					if (item.last) begin
						state_d = hsc_pkg::ST_START;
					end
				end
			end
			hsc_pkg::ST_START: begin
				if (count_q >= hsc_pkg::cnt_t'(2)) begin
					state_d = hsc_pkg::ST_LOAD_RD;
				end else begin
					state_d = hsc_pkg::ST_OUT_RD;
				end
			end
			hsc_pkg::ST_LOAD_RD: begin
				if (phase_q == hsc_pkg::PH_BUILD) begin
					mem_raddr_a = k_addr;
				end else begin
					mem_raddr_a = '0;
					mem_raddr_b = k_addr;
				end
				state_d = hsc_pkg::ST_LOAD_WR;
			end
			hsc_pkg::ST_LOAD_WR: begin
				// Extraction moves the root to the end of the heap; the old
				// end element becomes the value to sift from the root.
				if (phase_q == hsc_pkg::PH_EXTRACT) begin
					mem_we    = 1'b1;
					mem_waddr = k_addr;
					mem_wdata = mem_rdata_a;
				end
				state_d = hsc_pkg::ST_CHILD_RD;
			end
			hsc_pkg::ST_CHILD_RD: begin
				mem_raddr_a = hsc_pkg::addr_t'(lc_idx);
				mem_raddr_b = hsc_pkg::addr_t'(rc_idx);
				state_d     = hsc_pkg::ST_CHILD_CMP;
			end
			hsc_pkg::ST_CHILD_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = node_q;
				if (cmp_res.swap) begin
					mem_wdata = cmp_res.big_val;
					state_d   = hsc_pkg::ST_CHILD_RD;
				end else begin
					mem_wdata = held_q;
					state_d   = hsc_pkg::ST_NEXT;
				end
			end
			hsc_pkg::ST_NEXT: begin
				if ((phase_q == hsc_pkg::PH_EXTRACT) && (k_q <= hsc_pkg::cnt_t'(2))) begin
					state_d = hsc_pkg::ST_OUT_RD;
				end else begin
					state_d = hsc_pkg::ST_LOAD_RD;
				end
			end
			hsc_pkg::ST_OUT_RD: begin
				mem_raddr_a = hsc_pkg::addr_t'(out_idx_q);
				state_d     = hsc_pkg::ST_OUT_CAP;
			end
			hsc_pkg::ST_OUT_CAP: begin
				state_d = hsc_pkg::ST_OUT_WAIT;
			end
			hsc_pkg::ST_OUT_WAIT: begin
				if (!result_stall) begin
					if (result_q.final_item) begin
						state_d = hsc_pkg::ST_IDLE;
					end else begin
						state_d = hsc_pkg::ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = hsc_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= hsc_pkg::ST_IDLE;
			phase_q        <= hsc_pkg::PH_BUILD;
			count_q        <= '0;
			k_q            <= '0;
			len_q          <= '0;
			out_idx_q      <= '0;
			node_q         <= '0;
			total_q        <= '0;
			dropped_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				hsc_pkg::ST_IDLE: begin
					if (accept_in) begin
						if (room) begin
							count_q <= count_q + hsc_pkg::cnt_t'(1);
						end else begin
							dropped_q <= 1'b1;
						end
					end
				end
				hsc_pkg::ST_START: begin
					phase_q   <= hsc_pkg::PH_BUILD;
					k_q       <= count_q >> 1;
					out_idx_q <= '0;
					total_q   <= '0;
				end
				hsc_pkg::ST_LOAD_WR: begin
					if (phase_q == hsc_pkg::PH_BUILD) begin
						node_q <= k_addr;
						len_q  <= count_q;
					end else begin
						node_q <= '0;
						len_q  <= k_q - hsc_pkg::cnt_t'(1);
					end
				end
				hsc_pkg::ST_CHILD_CMP: begin
					// Every level examined counts two comparisons, saturating.
					if (total_q >= (hsc_pkg::CMP_MAX - hsc_pkg::cmp_cnt_t'(1))) begin
						total_q <= hsc_pkg::CMP_MAX;
					end else begin
						total_q <= total_q + hsc_pkg::cmp_cnt_t'(2);
					end
					if (cmp_res.swap) begin
						node_q <= cmp_res.pick_right ? hsc_pkg::addr_t'(rc_idx)
							: hsc_pkg::addr_t'(lc_idx);
					end
				end
				hsc_pkg::ST_NEXT: begin
					// The build ends after the root; extraction starts at the full set.
					if ((phase_q == hsc_pkg::PH_BUILD) && (k_q == hsc_pkg::cnt_t'(1))) begin
						phase_q <= hsc_pkg::PH_EXTRACT;
						k_q     <= count_q;
					end else begin
						k_q <= k_q - hsc_pkg::cnt_t'(1);
					end
				end
				hsc_pkg::ST_OUT_CAP: begin
					result_valid_q <= 1'b1;
				end
				hsc_pkg::ST_OUT_WAIT: begin
					if (!result_stall) begin
						result_valid_q <= 1'b0;
						if (result_q.final_item) begin
							count_q   <= '0;
							total_q   <= '0;
							dropped_q <= 1'b0;
						end else begin
							out_idx_q <= out_idx_q + hsc_pkg::cnt_t'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: sifted value and the result being offered.
	always_ff @(posedge clk) begin
		if (state_q == hsc_pkg::ST_LOAD_WR) begin
			held_q <= (phase_q == hsc_pkg::PH_BUILD) ? mem_rdata_a : mem_rdata_b;
		end
		if (state_q == hsc_pkg::ST_OUT_CAP) begin
			result_q.sorted_value  <= $signed(hsc_pkg::value_t'(mem_rdata_a));
			result_q.final_item    <= (out_idx_q == (count_q - hsc_pkg::cnt_t'(1)));
			result_q.compare_count <= total_q;
			result_q.overflow      <= dropped_q;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/heap_sort_with_compare_count_core.sv
// Elements load one per cycle while idle; after the last one the sort builds the
// heap and extracts the roots, sifting one level at a time, and then offers the
// results one by one, each held until taken. Items are taken only while idle.
// Throughput is set by the single element store and the shared compare unit.
// Reset clears all control state asynchronously; the element store is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// heap_sort_with_compare_count_core: heap sort with comparison counter
// Collects signed elements up to a marked last one, heap-sorts them in place
// and returns them in ascending order with the comparison total.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_with_compare_count_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hsc_pkg::in_item_t item,
	input  wire logic              item_valid,
	output logic                   item_stall,
	output hsc_pkg::out_item_t     result,
	output logic                   result_valid,
	input  wire logic              result_stall
);

	logic              mem_we;
	hsc_pkg::addr_t    mem_waddr;
	hsc_pkg::elem_t    mem_wdata;
	hsc_pkg::addr_t    mem_raddr_a;
	hsc_pkg::addr_t    mem_raddr_b;
	hsc_pkg::elem_t    mem_rdata_a;
	hsc_pkg::elem_t    mem_rdata_b;
	hsc_pkg::cmp_req_t cmp_req;
	hsc_pkg::cmp_res_t cmp_res;

	// Sequencer.
	hsc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr_a  (mem_raddr_a),
		.mem_raddr_b  (mem_raddr_b),
		.mem_rdata_a  (mem_rdata_a),
		.mem_rdata_b  (mem_rdata_b),
		.cmp_req      (cmp_req),
		.cmp_res      (cmp_res)
	);

	// Element store.
	hsc_ram #(
		.WIDTH (hsc_pkg::DATA_WIDTH),
		.DEPTH (hsc_pkg::DEPTH)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	// Shared compare unit.
	hsc_cmp u_cmp (
		.req (cmp_req),
		.res (cmp_res)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/hsc_checker.sv
// ----------------------------------------------------------------------------
// hsc_checker: port-level checks for the heap sort core
// Watches the handshakes and the ordering of loading, sorting and results.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire hsc_pkg::in_item_t  item,
	input wire logic               item_valid,
	input wire logic               item_stall,
	input wire hsc_pkg::out_item_t result,
	input wire logic               result_valid,
	input wire logic               result_stall
);

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// No new elements are taken while results are being offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("input open while results pending");

	// A transaction marked last starts the sort: the input closes next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.last |=> item_stall && !result_valid)
		else $error("sort did not start after last element");

	// After the final result is taken no further result follows at once and the input reopens.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.final_item |=> !result_valid && !item_stall)
		else $error("extra result after final element");

endmodule

bind heap_sort_with_compare_count_core hsc_checker u_hsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item         (item),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result       (result),
	.result_valid (result_valid),
	.result_stall (result_stall)
);

`default_nettype wire
